FILE: rtl/cmw_pkg.sv
// Shared types, constants and codes of the column melt wipe.
package cmw_pkg;

	localparam int COLUMN_PAIRS_DEF = 160;
	localparam int OFFSET_W         = 11;
	localparam int COL_W            = 8;
	localparam int ROW_W            = 10;
	localparam int CFG_IDX_W        = 1;
	localparam int CFG_DATA_W       = 10;

	localparam logic [ROW_W-1:0] HEIGHT_RESET = 10'd200;
	localparam int DELAY_STEP = 13;
	localparam int FAST_LIMIT = 16;
	localparam int SLOW_STEP  = 8;
	localparam int SEED_FLOOR = -15;

	// item kinds
	localparam logic [1:0] MODE_SEED  = 2'd0;
	localparam logic [1:0] MODE_TICK  = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_MODE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

	typedef logic signed [OFFSET_W-1:0] offset_t;

	typedef struct packed {
		logic [1:0]       mode;
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic [3:0]       random_value;
		logic [3:0]       tick_count;
	} cmw_in_t;

	typedef struct packed {
		logic             done_res;
		logic             from_end_screen;
		logic [ROW_W-1:0] source_row;
	} cmw_out_t;

	typedef struct packed {
		logic             re;
		logic             we;
		logic [COL_W-1:0] addr;
		offset_t          wdata;
	} cmw_mem_req_t;

	typedef struct packed {
		offset_t  next_offset;
		logic     moved;
		offset_t  seed_value;
		cmw_out_t query_res;
	} cmw_unit_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_QUERY_RD,
		ST_TICK_RD,
		ST_TICK_WR,
		ST_FINISH
	} cmw_state_t;

endpackage

FILE: rtl/cmw_offset_mem.sv
// Column offset memory with per-entry valid bits; unwritten entries read as zero.
module cmw_offset_mem #(
	parameter int DEPTH = cmw_pkg::COLUMN_PAIRS_DEF,
	parameter int AW    = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmw_pkg::cmw_mem_req_t req,
	output cmw_pkg::offset_t      rdata
);
	import cmw_pkg::*;

	offset_t          mem_q [DEPTH];
	logic [DEPTH-1:0] valid_q;
	offset_t          rd_data_q;
	logic             rd_valid_q;
	logic [AW-1:0]    addr;

	assign addr = req.addr[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[addr] <= 1'b1;
			end
			if (req.re) begin
				rd_valid_q <= valid_q[addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[addr] <= req.wdata;
		end
		if (req.re) begin
			rd_data_q <= mem_q[addr];
		end
	end

	assign rdata = rd_valid_q ? rd_data_q : '0;

endmodule

FILE: rtl/cmw_step_unit.sv
// Shared arithmetic unit: melt step, pixel source and seed value of one column.
module cmw_step_unit (
	input  logic                        delay_mode,
	input  logic [cmw_pkg::ROW_W-1:0]   screen_height,
	input  cmw_pkg::offset_t            offset_in,
	input  logic [cmw_pkg::ROW_W-1:0]   row,
	input  logic [3:0]                  random_value,
	input  logic                        first_column,
	input  cmw_pkg::offset_t            previous_seed,
	output cmw_pkg::cmw_unit_res_t      res
);
	import cmw_pkg::*;

	logic signed [OFFSET_W:0] y_ext;
	logic signed [OFFSET_W:0] h_ext;
	logic signed [OFFSET_W:0] row_ext;
	logic signed [OFFSET_W:0] dy;
	logic signed [OFFSET_W:0] sum;
	logic signed [OFFSET_W:0] seed_sum;
	logic [1:0]               rnd_mod3;

	function automatic logic [1:0] mod3(input logic [3:0] v);
		logic [1:0] m;
		unique case (v)
			4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: m = 2'd0;
			4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       m = 2'd1;
			default:                              m = 2'd2;
		endcase
		return m;
	endfunction

	assign y_ext    = (OFFSET_W+1)'(offset_in);
	assign h_ext    = $signed({2'b00, screen_height});
	assign row_ext  = $signed({2'b00, row});
	assign rnd_mod3 = mod3(random_value);

	// melt step
	always_comb begin
		res.moved       = 1'b0;
		res.next_offset = offset_in;
		if (delay_mode) begin
			dy = (OFFSET_W+1)'(DELAY_STEP);
		end else if (y_ext < (OFFSET_W+1)'(FAST_LIMIT)) begin
			dy = y_ext + 12'sd1;
		end else begin
			dy = (OFFSET_W+1)'(SLOW_STEP);
		end
		sum = y_ext + dy;
		if (y_ext < 0) begin
			res.moved       = 1'b1;
			res.next_offset = OFFSET_W'(y_ext + 12'sd1);
		end else if (y_ext < h_ext) begin
			res.moved       = 1'b1;
			res.next_offset = (sum >= h_ext) ? OFFSET_W'(h_ext) : OFFSET_W'(sum);
		end
	end

	// pixel source
	always_comb begin
		res.query_res.done_res = 1'b0;
		if (delay_mode || y_ext < 0) begin
			res.query_res.from_end_screen = 1'b0;
			res.query_res.source_row      = row;
		end else if (row_ext < y_ext) begin
			res.query_res.from_end_screen = 1'b1;
			res.query_res.source_row      = row;
		end else begin
			res.query_res.from_end_screen = 1'b0;
			res.query_res.source_row      = ROW_W'(row_ext - y_ext);
		end
	end

	// seed staircase: first column takes minus the draw, others step from the last seed
	always_comb begin
		seed_sum = (OFFSET_W+1)'(previous_seed) + $signed({10'b0, rnd_mod3}) - 12'sd1;
		if (first_column) begin
			res.seed_value = OFFSET_W'(-$signed({8'b0, random_value}));
		end else if (seed_sum > 0) begin
			res.seed_value = '0;
		end else if (seed_sum < (OFFSET_W+1)'(SEED_FLOOR)) begin
			res.seed_value = OFFSET_W'(SEED_FLOOR);
		end else begin
			res.seed_value = OFFSET_W'(seed_sum);
		end
	end

endmodule

FILE: rtl/column_melt_wipe.sv
// Top level of the column melt wipe: sequencer, configuration and result register.
//
//  channel | signals                          | role
//  --------+----------------------------------+------------------------------------
//  cfg     | cfg_we, cfg_index, cfg_data      | register write, taken on cfg_we
//  req     | req_valid, req_ready, req        | seed / tick / query transaction in
//  rsp     | rsp_valid, rsp_ready, rsp        | one result transaction per request
//
//  A tick walks the offset memory tick_count times, one column per read/write pair
//  through the single step unit; a new request is taken only back in idle.
//  Reset clears the valid bits of the offset memory at once, so no clearing pass runs.
//  A stalled rsp holds the finished result in the output register; the sequencer waits
//  in its finish state only while that register is still full.
module column_melt_wipe #(
	parameter int COLUMN_PAIRS = cmw_pkg::COLUMN_PAIRS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cmw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cmw_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  cmw_pkg::cmw_in_t                  req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output cmw_pkg::cmw_out_t                 rsp
);
	import cmw_pkg::*;

	localparam int AW = (COLUMN_PAIRS > 1) ? $clog2(COLUMN_PAIRS) : 1;
	localparam logic [AW-1:0] LAST_COL = AW'(COLUMN_PAIRS - 1);

	cmw_state_t    state_q, state_d;
	cmw_in_t       item_q;
	logic [AW-1:0] idx_q, idx_d;
	logic [3:0]    tick_q, tick_d;
	logic          done_q, done_d;
	cmw_out_t      res_q, res_d;
	logic          res_load;
	offset_t       prev_seed_q;
	logic          seed_load;
	logic          delay_q;
	logic [ROW_W-1:0] height_q;
	logic          rsp_valid_q;
	cmw_out_t      rsp_q;
	logic          out_free;

	cmw_mem_req_t  mem_req;
	offset_t       mem_rdata;
	offset_t       unit_y;
	cmw_unit_res_t unit_res;
	logic          col_ok;

	// column field is meaningful only for seed and query
	assign col_ok    = 9'(item_q.column) < 9'(COLUMN_PAIRS);
	assign req_ready = (state_q == ST_IDLE);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// a query beyond the column pairs sees a zero offset
	assign unit_y = (state_q == ST_QUERY_RD && !col_ok) ? '0 : mem_rdata;

	cmw_offset_mem #(
		.DEPTH (COLUMN_PAIRS),
		.AW    (AW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (mem_rdata)
	);

	cmw_step_unit u_unit (
		.delay_mode    (delay_q),
		.screen_height (height_q),
		.offset_in     (unit_y),
		.row           (item_q.row),
		.random_value  (item_q.random_value),
		.first_column  (item_q.column == '0),
		.previous_seed (prev_seed_q),
		.res           (unit_res)
	);

	// Sequencer: next state, memory port and result staging.
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		tick_d    = tick_q;
		done_d    = done_q;
		res_d     = '0;
		res_load  = 1'b0;
		seed_load = 1'b0;
		mem_req   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (item_q.mode)
					MODE_SEED: begin
						// out-of-range seed leaves all state alone
						mem_req.we    = col_ok;
						mem_req.addr  = item_q.column;
						mem_req.wdata = unit_res.seed_value;
						seed_load     = col_ok;
						res_load      = 1'b1;
						state_d       = ST_FINISH;
					end
					MODE_TICK: begin
						idx_d  = '0;
						tick_d = item_q.tick_count;
						done_d = 1'b1;
						if (item_q.tick_count == '0) begin
							res_load       = 1'b1;
							res_d.done_res = 1'b1;
							state_d        = ST_FINISH;
						end else begin
							state_d = ST_TICK_RD;
						end
					end
					MODE_QUERY: begin
						mem_req.re   = col_ok;
						mem_req.addr = item_q.column;
						state_d      = ST_QUERY_RD;
					end
					default: begin
						res_load = 1'b1;
						state_d  = ST_FINISH;
					end
				endcase
			end
			ST_QUERY_RD: begin
				res_load = 1'b1;
				res_d    = unit_res.query_res;
				state_d  = ST_FINISH;
			end
			ST_TICK_RD: begin
				mem_req.re   = 1'b1;
				mem_req.addr = COL_W'(idx_q);
				state_d      = ST_TICK_WR;
			end
			ST_TICK_WR: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = COL_W'(idx_q);
				mem_req.wdata = unit_res.next_offset;
				done_d        = done_q & ~unit_res.moved;
				if (idx_q == LAST_COL) begin
					idx_d = '0;
					if (tick_q == 4'd1) begin
						res_load       = 1'b1;
						res_d.done_res = done_d;
						state_d        = ST_FINISH;
					end else begin
						tick_d  = tick_q - 4'd1;
						state_d = ST_TICK_RD;
					end
				end else begin
					idx_d   = idx_q + AW'(1);
					state_d = ST_TICK_RD;
				end
			end
			ST_FINISH: begin
				// hand over to the output register once it is free
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			tick_q      <= '0;
			done_q      <= 1'b0;
			prev_seed_q <= '0;
			delay_q     <= 1'b0;
			height_q    <= HEIGHT_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			tick_q  <= tick_d;
			done_q  <= done_d;
			if (seed_load) begin
				prev_seed_q <= unit_res.seed_value;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DELAY_MODE:    delay_q  <= cfg_data[0];
					REG_SCREEN_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_FINISH && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload: capture the transaction, stage and present the result
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_q <= req;
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (state_q == ST_FINISH && out_free) begin
			rsp_q <= res_q;
		end
	end

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == ST_DISPATCH && !req_ready))
		else $error("accepted transaction did not move to dispatch");

	a_write_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TICK_WR) |-> ($past(state_q) == ST_TICK_RD))
		else $error("tick write-back without a preceding read");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TICK_RD || state_q == ST_TICK_WR) |-> (idx_q <= LAST_COL))
		else $error("tick walk index beyond last column");

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == ST_FINISH))
		else $error("result presented outside finish");

	a_seed_range: assert property (@(posedge clk) disable iff (!arst_n)
		(prev_seed_q <= 0) && (prev_seed_q >= -15))
		else $error("seed staircase left its range");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the column melt wipe: directed and random transactions.
module tb;
	import cmw_pkg::*;

	localparam int PAIRS           = COLUMN_PAIRS_DEF;
	localparam int PHASES          = 7;
	localparam int ITEMS_PER_PHASE = 94;
	localparam int RX_HOLD_CYCLES  = 400;
	// Slowest legal transaction is a 15-tick sweep plus the longest receiver hold and
	// gaps; allow several times that.
	localparam int WATCHDOG_LIMIT  = 30000;
	localparam int DRAIN_CYCLES    = 16;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic req_valid = 1'b0;
	logic req_ready;
	cmw_in_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	cmw_out_t rsp;

	// Stimulus and scoreboard
	cmw_in_t wipe_requests[$];
	cmw_out_t wipe_results_due[$];
	int items_queued = 0;
	int items_sent = 0;
	int results_checked = 0;
	int errors = 0;
	int quiet = 0;
	logic req_taken = 1'b0;
	logic rsp_taken = 1'b0;

	// Mirror of the wipe state and its registers
	offset_t slide[PAIRS];
	offset_t last_seeded;
	logic delay_on;
	logic [ROW_W-1:0] rows;

	// Generator state and pacing controls
	int gen_rows = int'(HEIGHT_RESET);
	int seed_next = 0;
	logic tx_gaps_on = 1'b1;
	logic rx_gaps_on = 1'b1;
	logic tx_hold = 1'b0;
	int tx_gap = 0;
	int hold_asked = 0;
	int hold_given = 0;
	int hold_left = 0;
	int stall_left = 0;

	int n_seed = 0;
	int n_tick = 0;
	int n_sweep = 0;
	int n_query = 0;
	int n_other = 0;

	int phase_delay[PHASES] = '{0, 1, 0, 1, 0, 1, 0};
	int phase_rows[PHASES]  = '{1023, 1023, 1, 1, 0, 200, 0};

	column_melt_wipe #(.COLUMN_PAIRS(PAIRS)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	// Apply one transaction to the mirrored state and return the result it must produce.
	function automatic cmw_out_t melt_step(cmw_in_t it);
		cmw_out_t res;
		int v;
		int y;
		int dy;
		int r;
		logic still;
		res = '0;
		case (it.mode)
			MODE_SEED: begin
				n_seed++;
				if (int'(it.column) < PAIRS) begin
					if (it.column == '0) begin
						v = -int'(it.random_value);
					end else begin
						v = int'(last_seeded) + (int'(it.random_value) % 3) - 1;
						if (v > 0) v = 0;
						if (v < SEED_FLOOR) v = SEED_FLOOR;
					end
					slide[it.column] = offset_t'(v);
					last_seeded = offset_t'(v);
				end
			end
			MODE_TICK: begin
				n_tick++;
				still = 1'b1;
				for (int t = 0; t < int'(it.tick_count); t++) begin
					n_sweep++;
					for (int i = 0; i < PAIRS; i++) begin
						y = int'(slide[i]);
						if (y < 0) begin
							y++;
							still = 1'b0;
						end else if (y < int'(rows)) begin
							if (delay_on) dy = DELAY_STEP;
							else dy = (y < FAST_LIMIT) ? y + 1 : SLOW_STEP;
							if (y + dy >= int'(rows)) dy = int'(rows) - y;
							y += dy;
							still = 1'b0;
						end
						slide[i] = offset_t'(y);
					end
				end
				res.done_res = still;
			end
			MODE_QUERY: begin
				n_query++;
				y = 0;
				if (int'(it.column) < PAIRS) y = int'(slide[it.column]);
				r = int'(it.row);
				if (delay_on || y < 0) begin
					res.source_row = it.row;
				end else if (r < y) begin
					res.from_end_screen = 1'b1;
					res.source_row = it.row;
				end else begin
					res.source_row = ROW_W'(r - y);
				end
			end
			default: n_other++;
		endcase
		return res;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Build one random transaction. Seeds mostly walk the columns in order from column 0,
	// as a real wipe setup does; stray columns and the unused mode break the pattern.
	function automatic cmw_in_t random_item();
		cmw_in_t it;
		int pick;
		int r;
		it.mode = MODE_SEED;
		it.column = COL_W'($urandom_range(0, 255));
		it.row = ROW_W'($urandom_range(0, 1023));
		it.random_value = 4'($urandom_range(0, 15));
		it.tick_count = 4'($urandom_range(0, 15));
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			if ($urandom_range(0, 9) != 0) begin
				it.column = COL_W'(seed_next);
				if (seed_next == PAIRS - 1 || $urandom_range(0, 15) == 0) seed_next = 0;
				else seed_next++;
			end
		end else if (pick < 57) begin
			it.mode = MODE_TICK;
			r = $urandom_range(0, 99);
			// keep sweeps short: each tick walks every column with a read and a write
			if (r < 45) it.tick_count = 4'd1;
			else if (r < 75) it.tick_count = 4'($urandom_range(0, 3));
			else if (r < 95) it.tick_count = 4'($urandom_range(4, 8));
			else it.tick_count = 4'($urandom_range(9, 15));
		end else if (pick < 95) begin
			it.mode = MODE_QUERY;
			if ($urandom_range(0, 1) == 0) it.column = COL_W'($urandom_range(0, seed_next + 4));
			if ($urandom_range(0, 9) < 6)
				it.row = ROW_W'($urandom_range(0,
					(gen_rows + 1 > 1023) ? 1023 : gen_rows + 1));
		end else begin
			it.mode = MODE_UNUSED;
		end
		return it;
	endfunction

	task automatic push_item(cmw_in_t it);
		wipe_requests.push_back(it);
		items_queued++;
	endtask

	task automatic push_fields(logic [1:0] m, int c, int r, int rnd, int t);
		cmw_in_t it;
		it.mode = m;
		it.column = COL_W'(c);
		it.row = ROW_W'(r);
		it.random_value = 4'(rnd);
		it.tick_count = 4'(t);
		push_item(it);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until every queued transaction is accepted and answered.
	task automatic wait_drained();
		while (items_sent != items_queued || wipe_results_due.size() != 0) @(negedge clk);
	endtask

	// Predict on each accepted request, check each accepted result, and watch for hangs.
	always @(posedge clk) begin
		cmw_out_t due;
		if (!arst_n) begin
			for (int i = 0; i < PAIRS; i++) slide[i] = '0;
			last_seeded = '0;
			delay_on = 1'b0;
			rows = HEIGHT_RESET;
			req_taken <= 1'b0;
			rsp_taken <= 1'b0;
			quiet = 0;
		end else begin
			req_taken <= req_valid && req_ready;
			rsp_taken <= rsp_valid && rsp_ready;
			if (cfg_we) begin
				case (cfg_index)
					REG_DELAY_MODE: delay_on = cfg_data[0];
					REG_SCREEN_HEIGHT: rows = cfg_data[ROW_W-1:0];
					default: ;
				endcase
			end
			if (req_valid && req_ready) begin
				wipe_results_due.push_back(melt_step(req));
				items_sent++;
			end
			if (rsp_valid && rsp_ready) begin
				if (wipe_results_due.size() == 0) begin
					$error("result transaction with nothing expected");
					errors++;
				end else begin
					due = wipe_results_due.pop_front();
					results_checked++;
					if (rsp.done_res !== due.done_res) begin
						$error("done_res: expected %0d, actual %0d", due.done_res, rsp.done_res);
						errors++;
					end
					if (rsp.from_end_screen !== due.from_end_screen) begin
						$error("from_end_screen: expected %0d, actual %0d",
							due.from_end_screen, rsp.from_end_screen);
						errors++;
					end
					if (rsp.source_row !== due.source_row) begin
						$error("source_row: expected %0d, actual %0d",
							due.source_row, rsp.source_row);
						errors++;
					end
				end
			end
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we) quiet = 0;
			else quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$error("no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Request driver: after each accepted transaction, idle for a random gap while gaps are on, then
	// offer the next pending item. Hold valid and payload until the block takes them.
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			if (req_taken && tx_gaps_on) tx_gap = pick_gap();
			if (tx_gap > 0) begin
				tx_gap--;
				req_valid <= 1'b0;
			end else if (wipe_requests.size() > 0 && !tx_hold) begin
				req <= wipe_requests.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result receiver: stall after some results and at random while idle, and honor
	// a requested long hold-off so the block backs up into its input.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else if (hold_asked != hold_given) begin
			hold_given++;
			hold_left = RX_HOLD_CYCLES - 1;
			rsp_ready <= 1'b0;
		end else begin
			if (rx_gaps_on && rsp_taken) stall_left = pick_gap();
			else if (rx_gaps_on && stall_left == 0 && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 4);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= arst_n;
			end
		end
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset registers (standard melt, 200 rows).
		push_fields(MODE_QUERY, 0, 0, 0, 0);          // untouched column
		push_fields(MODE_QUERY, 255, 1023, 0, 0);     // column past the pairs
		push_fields(MODE_SEED, 0, 0, 15, 0);          // deepest first column
		push_fields(MODE_SEED, 1, 0, 0, 0);           // clamp at the floor
		push_fields(MODE_SEED, 2, 0, 14, 0);          // step up
		push_fields(MODE_SEED, 200, 0, 5, 0);         // dropped seed, previous kept
		push_fields(MODE_SEED, 3, 0, 1, 0);           // no step
		push_fields(MODE_SEED, PAIRS - 1, 0, 2, 0);   // last column
		push_fields(MODE_QUERY, 0, 5, 0, 0);          // negative offset
		push_fields(MODE_QUERY, 200, 7, 0, 0);
		push_fields(MODE_TICK, 0, 0, 0, 0);           // zero ticks reports done
		push_fields(MODE_UNUSED, 255, 1023, 15, 15);  // unused mode answers zero
		push_fields(MODE_TICK, 0, 0, 0, 1);
		push_fields(MODE_QUERY, 5, 0, 0, 0);          // above the offset: end screen
		push_fields(MODE_QUERY, 5, 1023, 0, 0);       // row beyond the height
		push_fields(MODE_TICK, 0, 0, 0, 15);
		push_fields(MODE_TICK, 0, 0, 0, 15);
		push_fields(MODE_TICK, 0, 0, 0, 15);          // every column at the bottom
		push_fields(MODE_TICK, 0, 0, 0, 1);           // nothing moves: done
		push_fields(MODE_QUERY, 7, 199, 0, 0);
		push_fields(MODE_QUERY, 7, 200, 0, 0);
		push_fields(MODE_QUERY, 2, 1023, 0, 0);

		// Random phases, each under its own register setting.
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			if (p == PHASES - 1) begin
				phase_delay[p] = $urandom_range(0, 1);
				phase_rows[p] = $urandom_range(2, 1022);
			end
			write_reg(REG_DELAY_MODE, CFG_DATA_W'(phase_delay[p]));
			write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'(phase_rows[p]));
			@(posedge clk);
			gen_rows = phase_rows[p];
			// run one phase back to back on both sides
			tx_gaps_on = (p != 1);
			rx_gaps_on = (p != 1);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) push_item(random_item());
			// stall the receiver long enough for the block to back up
			if (p == 0) hold_asked++;
			// halfway through, stop sending until every result is back
			if (p == 3) begin
				while (items_sent < items_queued - ITEMS_PER_PHASE / 2) @(negedge clk);
				@(posedge clk);
				tx_hold = 1'b1;
				while (req_valid || wipe_results_due.size() != 0) @(negedge clk);
				@(posedge clk);
				tx_hold = 1'b0;
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (wipe_results_due.size() != 0) begin
			$error("%0d results never arrived", wipe_results_due.size());
			errors++;
		end
		$display("Run covered %0d seeds, %0d ticks (%0d sweeps), %0d queries, %0d unused",
			n_seed, n_tick, n_sweep, n_query, n_other);
		$display("over %0d register settings; %0d results checked, %0d mismatches",
			PHASES + 1, results_checked, errors);
		if (errors == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule
